// ===== hw/rtl/pws_pkg.sv =====
// Shared types and constants of the polyphonic wavetable synthesizer.
`default_nettype none

package pws_pkg;

	localparam int ACTION_W = 3;
	localparam int KEY_W    = 7;
	localparam int VEL_W    = 7;
	localparam int INDEX_W  = 7;
	localparam int WAVE_W   = 16;
	localparam int STEP_W   = 22;
	localparam int PHASE_W  = 22;
	localparam int SAMPLE_W = 12;

	localparam logic [ACTION_W-1:0] ACT_NOTE_ON  = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_NOTE_OFF = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_TICK     = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_WR_WAVE  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_WR_STEP  = 3'd4;

	// table write request
	typedef struct packed {
		logic               wave_we;
		logic               step_we;
		logic [INDEX_W-1:0] addr;
		logic [WAVE_W-1:0]  wave;
		logic [STEP_W-1:0]  step;
	} tbl_wr_t;

	// multiply-accumulate control
	typedef struct packed {
		logic clear;
		logic acc_en;
	} mac_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pws_tables.sv =====
// Wave and step table memories with registered read ports.
`default_nettype none

module pws_tables #(
	parameter int WAVE_LEN   = 50,
	parameter int NOTE_COUNT = 128,
	parameter int WA_W       = 6,
	parameter int SA_W       = 7
) (
	input  wire                          clk,
	input  wire pws_pkg::tbl_wr_t        wr,
	input  wire                          wave_rd_en,
	input  wire  [WA_W-1:0]              wave_rd_addr,
	input  wire                          step_rd_en,
	input  wire  [SA_W-1:0]              step_rd_addr,
	output logic [pws_pkg::WAVE_W-1:0]   wave_rd_data,
	output logic [pws_pkg::STEP_W-1:0]   step_rd_data
);

	logic [pws_pkg::WAVE_W-1:0] wave_mem [WAVE_LEN];
	logic [pws_pkg::STEP_W-1:0] step_mem [NOTE_COUNT];

	always_ff @(posedge clk) begin
		if (wr.wave_we) begin
			wave_mem[wr.addr[WA_W-1:0]] <= wr.wave;
		end
		if (wave_rd_en) begin
			wave_rd_data <= wave_mem[wave_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.step_we) begin
			step_mem[wr.addr[SA_W-1:0]] <= wr.step;
		end
		if (step_rd_en) begin
			step_rd_data <= step_mem[step_rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/pws_mac.sv =====
// Shared multiply-accumulate unit and output scaling of the voice mix.
`default_nettype none

module pws_mac #(
	parameter int VOICE_COUNT = 6
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire pws_pkg::mac_ctrl_t       ctrl,
	input  wire  [pws_pkg::WAVE_W-1:0]    wave,
	input  wire                           wave_zero,
	input  wire  [pws_pkg::VEL_W-1:0]     volume,
	output logic [pws_pkg::SAMPLE_W-1:0]  sample
);

	localparam int ACC_W  = 20 + $clog2(VOICE_COUNT);
	localparam int PROD_W = pws_pkg::WAVE_W + pws_pkg::VEL_W + 1;

	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  term;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  biased;
	logic signed [ACC_W-1:0]  shifted;
	logic signed [ACC_W-1:0]  scaled;

	assign prod = $signed(wave) * $signed({1'b0, volume});

	// floor division by 16: drop four bits of the signed product
	always_comb begin
		if (wave_zero) begin
			term = '0;
		end else begin
			term = ACC_W'($signed(prod[PROD_W-1:4]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.clear) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + term;
		end
	end

	// divide by 1024 toward zero, offset to mid scale, clamp
	always_comb begin
		biased  = acc_q + (acc_q[ACC_W-1] ? ACC_W'(1023) : ACC_W'(0));
		shifted = biased >>> 10;
		scaled  = shifted + ACC_W'(2048);
		if (scaled[ACC_W-1]) begin
			sample = '0;
		end else if (scaled > ACC_W'(4095)) begin
			sample = pws_pkg::SAMPLE_W'(4095);
		end else begin
			sample = scaled[pws_pkg::SAMPLE_W-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/polyphonic_wavetable_synth.sv =====
// Top level of the polyphonic wavetable synthesizer: request sequencer and voice state.
`default_nettype none

// Each request is taken while the block is idle and then worked off by a small
// sequencer that walks the voices one at a time through one multiply-accumulate
// unit and one wave table read port. A table write is done as it is taken and
// leaves the block idle. A note on or note off scans for the first free or
// matching voice. A sample tick passes over each inactive voice and takes each
// active voice through a phase step (phase update and wave read) and then a
// multiply-accumulate step. The sample waits in an output register; a tick that
// finds it still untaken holds in its final step until it is.
module polyphonic_wavetable_synth #(
	parameter int VOICE_COUNT = 6,
	parameter int WAVE_LEN    = 50,
	parameter int NOTE_COUNT  = 128
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// key[6:0], velocity[13:7], table_index[20:14], wave_value[36:21],
	// step_value[58:37], zero[63:59]
	input  wire  [63:0] s_tdata,
	// action[2:0]
	input  wire  [2:0]  s_tuser,
	output logic        m_tvalid,
	input  wire         m_tready,
	// sample[11:0], zero[15:12]
	output logic [15:0] m_tdata
);

	localparam int VI_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int WA_W = $clog2(WAVE_LEN);
	localparam int SA_W = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
	localparam logic [pws_pkg::PHASE_W:0] WRAP = (pws_pkg::PHASE_W + 1)'(WAVE_LEN * 65536);

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_SCAN     = 5'b00010,
		ST_TICK_PH  = 5'b00100,
		ST_TICK_MAC = 5'b01000,
		ST_FIN      = 5'b10000
	} state_t;

	state_t state_q;

	logic [pws_pkg::ACTION_W-1:0] action;
	logic [pws_pkg::KEY_W-1:0]    key;
	logic [pws_pkg::VEL_W-1:0]    velocity;
	logic [pws_pkg::INDEX_W-1:0]  table_index;
	logic [pws_pkg::WAVE_W-1:0]   wave_value;
	logic [pws_pkg::STEP_W-1:0]   step_value;

	assign action      = s_tuser;
	assign key         = s_tdata[6:0];
	assign velocity    = s_tdata[13:7];
	assign table_index = s_tdata[20:14];
	assign wave_value  = s_tdata[36:21];
	assign step_value  = s_tdata[58:37];

	logic accept;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// voice state
	logic [VOICE_COUNT-1:0]     active_q;
	logic [pws_pkg::KEY_W-1:0]  note_q  [VOICE_COUNT];
	logic [pws_pkg::VEL_W-1:0]  vol_q   [VOICE_COUNT];
	logic [pws_pkg::STEP_W-1:0] step_q  [VOICE_COUNT];
	logic [pws_pkg::PHASE_W-1:0] phase_q [VOICE_COUNT];

	// latched request
	logic [pws_pkg::KEY_W-1:0] key_q;
	logic [pws_pkg::VEL_W-1:0] vel_q;
	logic                      release_q;
	logic                      key_oob_q;
	logic [VI_W-1:0]           vidx_q;
	logic                      wave_zero_q;

	logic [pws_pkg::SAMPLE_W-1:0] sample_q;
	logic                         m_tvalid_q;

	// table port
	pws_pkg::tbl_wr_t           tbl_wr;
	logic                       wave_rd_en;
	logic [WA_W-1:0]            wave_rd_addr;
	logic [pws_pkg::WAVE_W-1:0] wave_rd_data;
	logic [pws_pkg::STEP_W-1:0] step_rd_data;

	pws_pkg::mac_ctrl_t           mac_ctrl;
	logic [pws_pkg::SAMPLE_W-1:0] mix_sample;

	logic                        cur_active;
	logic                        last_voice;
	logic [pws_pkg::PHASE_W:0]   ph_sum;
	logic [pws_pkg::PHASE_W:0]   ph_wrapped;
	logic [pws_pkg::PHASE_W-1:0] ph_new;
	logic [5:0]                  ph_idx;
	logic                        ph_in_range;
	logic                        out_free;

	assign cur_active = active_q[vidx_q];
	assign last_voice = (vidx_q == VI_W'(VOICE_COUNT - 1));
	assign out_free   = !m_tvalid_q || m_tready;

	always_comb begin
		ph_sum      = {1'b0, phase_q[vidx_q]} + {1'b0, step_q[vidx_q]};
		ph_wrapped  = (ph_sum >= WRAP) ? (ph_sum - WRAP) : ph_sum;
		ph_new      = ph_wrapped[pws_pkg::PHASE_W-1:0];
		ph_idx      = ph_new[pws_pkg::PHASE_W-1:16];
		ph_in_range = (7'(ph_idx) < 7'(WAVE_LEN));
	end

	always_comb begin
		tbl_wr.wave_we = accept && (action == pws_pkg::ACT_WR_WAVE) &&
			(8'(table_index) < 8'(WAVE_LEN));
		tbl_wr.step_we = accept && (action == pws_pkg::ACT_WR_STEP) &&
			(8'(table_index) < 8'(NOTE_COUNT));
		tbl_wr.addr    = table_index;
		tbl_wr.wave    = wave_value;
		tbl_wr.step    = step_value;
	end

	assign wave_rd_en   = (state_q == ST_TICK_PH) && cur_active;
	assign wave_rd_addr = ph_idx[WA_W-1:0];

	assign mac_ctrl.clear  = accept && (action == pws_pkg::ACT_TICK);
	assign mac_ctrl.acc_en = (state_q == ST_TICK_MAC);

	pws_tables #(
		.WAVE_LEN  (WAVE_LEN),
		.NOTE_COUNT(NOTE_COUNT),
		.WA_W      (WA_W),
		.SA_W      (SA_W)
	) u_tables (
		.clk         (clk),
		.wr          (tbl_wr),
		.wave_rd_en  (wave_rd_en),
		.wave_rd_addr(wave_rd_addr),
		.step_rd_en  (accept),
		.step_rd_addr(key[SA_W-1:0]),
		.wave_rd_data(wave_rd_data),
		.step_rd_data(step_rd_data)
	);

	pws_mac #(
		.VOICE_COUNT(VOICE_COUNT)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (mac_ctrl),
		.wave     (wave_rd_data),
		.wave_zero(wave_zero_q),
		.volume   (vol_q[vidx_q]),
		.sample   (mix_sample)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			vidx_q     <= '0;
			active_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					vidx_q <= '0;
					if (accept) begin
						if (action == pws_pkg::ACT_NOTE_ON || action == pws_pkg::ACT_NOTE_OFF) begin
							state_q <= ST_SCAN;
						end else if (action == pws_pkg::ACT_TICK) begin
							state_q <= ST_TICK_PH;
						end
					end
				end
				ST_SCAN: begin
					if (release_q) begin
						if (cur_active && note_q[vidx_q] == key_q) begin
							active_q[vidx_q] <= 1'b0;
							state_q          <= ST_IDLE;
						end else if (last_voice) begin
							state_q <= ST_IDLE;
						end else begin
							vidx_q <= vidx_q + 1'b1;
						end
					end else begin
						if (!cur_active) begin
							active_q[vidx_q] <= 1'b1;
							state_q          <= ST_IDLE;
						end else if (last_voice) begin
							// no free voice: drop the note
							state_q <= ST_IDLE;
						end else begin
							vidx_q <= vidx_q + 1'b1;
						end
					end
				end
				ST_TICK_PH: begin
					if (cur_active) begin
						state_q <= ST_TICK_MAC;
					end else if (last_voice) begin
						state_q <= ST_FIN;
					end else begin
						vidx_q <= vidx_q + 1'b1;
					end
				end
				ST_TICK_MAC: begin
					if (last_voice) begin
						state_q <= ST_FIN;
					end else begin
						vidx_q  <= vidx_q + 1'b1;
						state_q <= ST_TICK_PH;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request and voice payload
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q     <= key;
			vel_q     <= velocity;
			release_q <= (action == pws_pkg::ACT_NOTE_OFF) || (velocity == '0);
			key_oob_q <= (8'(key) >= 8'(NOTE_COUNT));
		end
		if (state_q == ST_SCAN && !release_q && !cur_active) begin
			note_q[vidx_q]  <= key_q;
			vol_q[vidx_q]   <= vel_q;
			step_q[vidx_q]  <= key_oob_q ? '0 : step_rd_data;
			phase_q[vidx_q] <= '0;
		end
		if (wave_rd_en) begin
			phase_q[vidx_q] <= ph_new;
			wave_zero_q     <= !ph_in_range;
		end
		if (state_q == ST_FIN && out_free) begin
			sample_q <= mix_sample;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, sample_q};

	a_vidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		vidx_q <= VI_W'(VOICE_COUNT - 1))
		else $error("voice index beyond last voice");

	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && m_tvalid && !m_tready) |=> (state_q == ST_FIN))
		else $error("sample overwritten before it was taken");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_FIN))
		else $error("output valid raised outside final tick step");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TICK_MAC) |-> $past(state_q == ST_TICK_PH))
		else $error("accumulate step without phase step");

endmodule

`default_nettype wire
